// ===== src/ilie_pkg.sv =====
// Shared types, codes and widths for the indexed list insert/edit block.
package ilie_pkg;

    // Width of the element count and of the broadcast index (capacity up to 64)
    localparam int unsigned IDX_W = 7;
    localparam int unsigned CAPACITY_DEF = 32;

    // Action codes of an input word
    localparam logic [1:0] ACT_APPEND  = 2'd0;
    localparam logic [1:0] ACT_INSERT  = 2'd1;
    localparam logic [1:0] ACT_EDIT    = 2'd2;
    localparam logic [1:0] ACT_DISPLAY = 2'd3;

    // Status codes of a result word
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_INDEX = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    // Operations broadcast to every cell of the chain
    localparam logic [2:0] OP_NONE   = 3'd0;
    localparam logic [2:0] OP_APPEND = 3'd1;
    localparam logic [2:0] OP_INSERT = 3'd2;
    localparam logic [2:0] OP_EDIT   = 3'd3;
    localparam logic [2:0] OP_ROTATE = 3'd4;

    typedef struct packed {
        logic [1:0]         action;
        logic [5:0]         position;
        logic signed [31:0] value;
    } t_in_word;

    typedef struct packed {
        logic [1:0]         status;
        logic [5:0]         count;
        logic               is_empty;
        logic               is_full;
        logic signed [31:0] element;
        logic               element_valid;
        logic               last;
    } t_out_word;

    // Control broadcast from the sequencer to the cells
    typedef struct packed {
        logic [2:0]         op;
        logic [IDX_W-1:0]   pos;
        logic [IDX_W-1:0]   count;
        logic signed [31:0] value;
    } t_bcast;

endpackage

// ===== src/indexed_list_insert_edit.sv =====
// Top level of the indexed list: sequencer, count and the chain of cells.
//
//  channel   | handshake                | word
//  ----------+--------------------------+---------------------------------
//  input     | i_in_valid / o_in_stall  | i_in_word  (action, position, value)
//  output    | o_out_valid / i_out_stall| o_out_word (status, count, flags, element)
//
// In an append, insert or edit all cells shift or load at once. A display
// rotates the occupied cells toward cell 0, one element leaves per cycle while
// the output is not stalled, and once all have left the order is restored.
// Reset clears the count and the sequencer; the cells hold no reset value.
// A stalled output holds its word; input stalls in display or until output free.
module indexed_list_insert_edit #(
    parameter int unsigned CAPACITY = ilie_pkg::CAPACITY_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  ilie_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ilie_pkg::t_out_word o_out_word
);
    import ilie_pkg::*;

    localparam logic [IDX_W-1:0] CAP = IDX_W'(CAPACITY);
    localparam logic S_IDLE = 1'b0;
    localparam logic S_DISP = 1'b1;

    logic               r_state, n_state;
    logic [IDX_W-1:0]   r_count, n_count;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic               r_out_valid, n_out_valid;
    t_out_word          r_out, n_out;

    t_bcast             bc;
    logic               out_free;
    logic               accept;
    logic [IDX_W-1:0]   pos_ext;
    logic [IDX_W-1:0]   count_after;
    logic signed [31:0] cell_data [CAPACITY];

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == S_IDLE) && out_free);
    assign accept     = i_in_valid && !o_in_stall;
    assign pos_ext    = IDX_W'(i_in_word.position);

    // Decode the action, update the count and build the result word
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        bc.op       = OP_NONE;
        bc.pos      = pos_ext;
        bc.count    = r_count;
        bc.value    = i_in_word.value;
        count_after = r_count;

        if (r_state == S_IDLE) begin
            if (accept) begin
                n_out.status        = ST_OK;
                n_out.element       = '0;
                n_out.element_valid = 1'b0;
                n_out.last          = 1'b1;
                case (i_in_word.action)
                    ACT_APPEND: begin
                        if (r_count >= CAP) begin
                            n_out.status = ST_FULL;
                        end else begin
                            bc.op       = OP_APPEND;
                            count_after = r_count + 1'b1;
                        end
                    end
                    ACT_INSERT: begin
                        if (pos_ext > r_count) begin
                            n_out.status = ST_BAD_INDEX;
                        end else if (r_count >= CAP) begin
                            n_out.status = ST_FULL;
                        end else begin
                            bc.op       = OP_INSERT;
                            count_after = r_count + 1'b1;
                        end
                    end
                    ACT_EDIT: begin
                        if (pos_ext >= r_count) begin
                            n_out.status = ST_BAD_INDEX;
                        end else begin
                            bc.op = OP_EDIT;
                        end
                    end
                    default: begin
                        // display: stream from cell 0 unless the list is empty
                        if (r_count != '0) begin
                            n_out.element       = cell_data[0];
                            n_out.element_valid = 1'b1;
                            n_out.last          = (r_count == IDX_W'(1));
                            bc.op               = OP_ROTATE;
                            n_idx               = IDX_W'(1);
                            if (r_count != IDX_W'(1)) begin
                                n_state = S_DISP;
                            end
                        end
                    end
                endcase
                n_count        = count_after;
                n_out.count    = count_after[5:0];
                n_out.is_empty = (count_after == '0);
                n_out.is_full  = (count_after == CAP);
                n_out_valid    = 1'b1;
            end
        end else begin
            // advance the display by one element when the output is free
            if (out_free) begin
                n_out.status        = ST_OK;
                n_out.count         = r_count[5:0];
                n_out.is_empty      = 1'b0;
                n_out.is_full       = (r_count == CAP);
                n_out.element       = cell_data[0];
                n_out.element_valid = 1'b1;
                n_out.last          = (r_idx + 1'b1 == r_count);
                n_out_valid         = 1'b1;
                bc.op               = OP_ROTATE;
                n_idx               = r_idx + 1'b1;
                if (r_idx + 1'b1 == r_count) begin
                    n_state = S_IDLE;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // Hold the result word while it waits
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // Chain of cells, each linked to its neighbors and to the head
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [31:0] left_d;
        logic signed [31:0] right_d;
        if (g == 0) begin : g_first
            assign left_d = cell_data[0];
        end else begin : g_inner_l
            assign left_d = cell_data[g-1];
        end
        if (g == CAPACITY - 1) begin : g_end
            assign right_d = cell_data[g];
        end else begin : g_inner_r
            assign right_d = cell_data[g+1];
        end
        ilie_cell #(
            .INDEX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_bc    (bc),
            .i_left  (left_d),
            .i_right (right_d),
            .i_head  (cell_data[0]),
            .o_data  (cell_data[g])
        );
    end

endmodule

// ===== src/ilie_cell.sv =====
// One storage cell of the list chain: holds the element at its own index.
module ilie_cell #(
    parameter int unsigned INDEX = 0
) (
    input  logic                i_clk,
    input  ilie_pkg::t_bcast    i_bc,
    input  logic signed [31:0]  i_left,
    input  logic signed [31:0]  i_right,
    input  logic signed [31:0]  i_head,
    output logic signed [31:0]  o_data
);
    import ilie_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX  = IDX_W'(INDEX);
    localparam logic [IDX_W-1:0] NXT_IDX = IDX_W'(INDEX + 1);

    logic signed [31:0] r_data;
    logic signed [31:0] n_data;

    // Pick this cell's next content from the broadcast operation
    always_comb begin
        n_data = r_data;
        case (i_bc.op)
            OP_APPEND: begin
                if (MY_IDX == i_bc.count) begin
                    n_data = i_bc.value;
                end
            end
            OP_INSERT: begin
                if (MY_IDX == i_bc.pos) begin
                    n_data = i_bc.value;
                end else if (MY_IDX > i_bc.pos && MY_IDX <= i_bc.count) begin
                    n_data = i_left;
                end
            end
            OP_EDIT: begin
                if (MY_IDX == i_bc.pos) begin
                    n_data = i_bc.value;
                end
            end
            OP_ROTATE: begin
                // rotate the occupied part toward the head
                if (NXT_IDX < i_bc.count) begin
                    n_data = i_right;
                end else if (NXT_IDX == i_bc.count) begin
                    n_data = i_head;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule
